// ===== design/mrtu_pkg.sv =====
// Shared types, constants and the CRC-16/Modbus byte fold for the
// Modbus RTU request receiver. No dependencies.
package mrtu_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;
    localparam int CRC_W  = 16;

    // Function code ranges that the receiver accepts
    localparam logic [BYTE_W-1:0] FC_LOW_FIRST   = 8'h01;
    localparam logic [BYTE_W-1:0] FC_LOW_LAST    = 8'h06;
    localparam logic [BYTE_W-1:0] FC_MULTI_COILS = 8'h0F;
    localparam logic [BYTE_W-1:0] FC_MULTI_REGS  = 8'h10;

    // Bytes still expected once the function code is known
    localparam logic [POS_W-1:0] FIXED_TAIL_LEN  = 9'd6;
    localparam logic [POS_W-1:0] MULTI_HEAD_LEN  = 9'd5;
    localparam logic [POS_W-1:0] CRC_BYTES       = 9'd2;
    // Shortest complete frame (fixed-length request)
    localparam logic [POS_W-1:0] MIN_FRAME_LEN   = 9'd8;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    localparam logic [BYTE_W-1:0] SLAVE_ADDR_RST = 8'h01;

    // Status reported with each result
    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD_CRC = 2'd2,
        ST_ILLEGAL = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  byte_position;
        frame_status_t     frame_status;
        logic [BYTE_W-1:0] function_code;
        logic [POS_W-1:0]  frame_length;
    } result_t;

    // Fold one byte into a reflected CRC-16 (poly 0xA001)
    function automatic logic [CRC_W-1:0] crc16_fold(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/modbus_rtu_request_receiver_core.sv =====
// Modbus RTU request receiver: one received byte in, one result out per byte,
// with frame tracking and CRC-16/Modbus check. The receiver takes one byte
// transaction every clock cycle while the result side keeps up; a byte accepted
// into the input register moves on to the result register, and its result is
// valid from then on. A stalled result side holds the input once both registers
// are full. The CRC is updated with a byte-wide XOR network in the parser as
// each byte moves between those registers. Every byte yields exactly one result.
// The slave address register resets to 1 and is written through cfg_wr_en.
// Depends on mrtu_pkg, mrtu_in_reg, mrtu_parser, mrtu_out_reg.
module modbus_rtu_request_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic [8:0] byte_position,
    output logic [1:0] frame_status,
    output logic [7:0] function_code,
    output logic [8:0] frame_length
);

    logic              q_valid;
    logic [7:0]        q_byte;
    logic              can_load;
    logic              take;
    mrtu_pkg::result_t res_comb;
    mrtu_pkg::result_t res_out;

    // Byte moves into the result register when there is room
    assign take = q_valid && can_load;

    mrtu_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .q_valid  (q_valid),
        .q_byte   (q_byte)
    );

    mrtu_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (take),
        .in_byte     (q_byte),
        .res         (res_comb)
    );

    mrtu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_in    (res_comb),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign data_byte     = res_out.data_byte;
    assign byte_position = res_out.byte_position;
    assign frame_status  = res_out.frame_status;
    assign function_code = res_out.function_code;
    assign frame_length  = res_out.frame_length;

`ifndef SYNTHESIS
    // A dropped byte carries no frame information
    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_position == 9'd0 |->
            frame_status == mrtu_pkg::ST_BUSY && function_code == 8'd0)
        else $error("dropped byte reports frame data");

    // Illegal function is only reported on the function code byte
    a_illegal_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == mrtu_pkg::ST_ILLEGAL |-> byte_position == 9'd2)
        else $error("illegal function away from byte 2");

    // Frame length only with a CRC verdict, and then equal to the position
    a_len_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_length != 9'd0 |->
            (frame_status == mrtu_pkg::ST_GOOD || frame_status == mrtu_pkg::ST_BAD_CRC)
            && frame_length == byte_position)
        else $error("frame length outside frame end");

    // A completed frame is never shorter than a fixed-length request
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status == mrtu_pkg::ST_GOOD ||
                      frame_status == mrtu_pkg::ST_BAD_CRC) |->
            frame_length >= mrtu_pkg::MIN_FRAME_LEN)
        else $error("frame shorter than minimum");

    // Stalled output keeps the input register from being overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !can_load |-> !in_ready)
        else $error("input register accepts while full and blocked");
`endif

endmodule

// ===== design/mrtu_in_reg.sv =====
// Input register for the receiver: holds one byte transaction.
// Uses mrtu_pkg for widths.
module mrtu_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mrtu_pkg::BYTE_W-1:0] rx_byte,
    input  logic                       take,
    output logic                       q_valid,
    output logic [mrtu_pkg::BYTE_W-1:0] q_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [mrtu_pkg::BYTE_W-1:0] byte_reg;

    // Free when empty or when the held byte moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;

endmodule

// ===== design/mrtu_parser.sv =====
// Frame tracking, running CRC and result formation for one byte per cycle while step is high.
// Uses mrtu_pkg for types, constants and crc16_fold.
module mrtu_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mrtu_pkg::BYTE_W-1:0] cfg_wr_data,
    input  logic                        step,
    input  logic [mrtu_pkg::BYTE_W-1:0] in_byte,
    output mrtu_pkg::result_t           res
);

    logic [mrtu_pkg::POS_W-1:0]  taken_reg,  taken_next;
    logic [mrtu_pkg::POS_W-1:0]  remain_reg, remain_next;
    logic                        await_reg,  await_next;
    logic [mrtu_pkg::CRC_W-1:0]  crc_reg,    crc_next;
    logic [mrtu_pkg::BYTE_W-1:0] tail0_reg,  tail0_next;
    logic [mrtu_pkg::BYTE_W-1:0] tail1_reg,  tail1_next;
    logic [mrtu_pkg::BYTE_W-1:0] held_fn_reg, held_fn_next;
    logic [mrtu_pkg::BYTE_W-1:0] slave_addr_reg;

    logic [mrtu_pkg::POS_W-1:0]  taken_inc;
    logic [mrtu_pkg::POS_W-1:0]  remain_dec;
    logic [mrtu_pkg::CRC_W-1:0]  crc_folded;
    logic                        crc_ok;

    assign taken_inc  = taken_reg + 9'd1;
    assign remain_dec = (remain_reg == '0) ? '0 : remain_reg - 9'd1;
    // Byte leaving the two-byte hold goes into the CRC
    assign crc_folded = (taken_reg >= 9'd2) ? mrtu_pkg::crc16_fold(crc_reg, tail0_reg)
                                            : crc_reg;
    assign crc_ok     = (tail1_reg == crc_folded[7:0]) && (in_byte == crc_folded[15:8]);

    // Next frame state and result for the byte in the input register
    always_comb
    begin
        taken_next   = taken_reg;
        remain_next  = remain_reg;
        await_next   = await_reg;
        crc_next     = crc_reg;
        tail0_next   = tail0_reg;
        tail1_next   = tail1_reg;
        held_fn_next = held_fn_reg;

        res.data_byte     = in_byte;
        res.byte_position = '0;
        res.frame_status  = mrtu_pkg::ST_BUSY;
        res.function_code = '0;
        res.frame_length  = '0;

        if (taken_reg == '0)
        begin
            // Address byte: keep it only on a match
            if (in_byte == slave_addr_reg)
            begin
                taken_next        = 9'd1;
                tail0_next        = '0;
                tail1_next        = in_byte;
                res.byte_position = 9'd1;
            end
        end
        else
        begin
            crc_next          = crc_folded;
            tail0_next        = tail1_reg;
            tail1_next        = in_byte;
            taken_next        = taken_inc;
            res.byte_position = taken_inc;

            if (taken_inc == 9'd2)
            begin
                // Function code
                res.function_code = in_byte;
                if (in_byte >= mrtu_pkg::FC_LOW_FIRST && in_byte <= mrtu_pkg::FC_LOW_LAST)
                begin
                    held_fn_next = in_byte;
                    remain_next  = mrtu_pkg::FIXED_TAIL_LEN;
                    await_next   = 1'b0;
                end
                else if (in_byte == mrtu_pkg::FC_MULTI_COILS ||
                         in_byte == mrtu_pkg::FC_MULTI_REGS)
                begin
                    held_fn_next = in_byte;
                    remain_next  = mrtu_pkg::MULTI_HEAD_LEN;
                    await_next   = 1'b1;
                end
                else
                begin
                    res.frame_status = mrtu_pkg::ST_ILLEGAL;
                    taken_next   = '0;
                    remain_next  = '0;
                    await_next   = 1'b0;
                    crc_next     = mrtu_pkg::CRC_INIT;
                    tail0_next   = '0;
                    tail1_next   = '0;
                    held_fn_next = '0;
                end
            end
            else
            begin
                res.function_code = held_fn_reg;
                remain_next       = remain_dec;
                if (remain_dec == '0)
                begin
                    if (await_reg)
                    begin
                        // Byte count: data bytes plus the CRC pair
                        remain_next = {1'b0, in_byte} + mrtu_pkg::CRC_BYTES;
                        await_next  = 1'b0;
                    end
                    else
                    begin
                        // Frame end
                        res.frame_status = crc_ok ? mrtu_pkg::ST_GOOD : mrtu_pkg::ST_BAD_CRC;
                        res.frame_length = taken_inc;
                        taken_next   = '0;
                        remain_next  = '0;
                        await_next   = 1'b0;
                        crc_next     = mrtu_pkg::CRC_INIT;
                        tail0_next   = '0;
                        tail1_next   = '0;
                        held_fn_next = '0;
                    end
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg   <= '0;
            remain_reg  <= '0;
            await_reg   <= 1'b0;
            crc_reg     <= mrtu_pkg::CRC_INIT;
            tail0_reg   <= '0;
            tail1_reg   <= '0;
            held_fn_reg <= '0;
        end
        else if (step)
        begin
            taken_reg   <= taken_next;
            remain_reg  <= remain_next;
            await_reg   <= await_next;
            crc_reg     <= crc_next;
            tail0_reg   <= tail0_next;
            tail1_reg   <= tail1_next;
            held_fn_reg <= held_fn_next;
        end
    end

    // Slave address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= mrtu_pkg::SLAVE_ADDR_RST;
        end
        else if (cfg_wr_en)
        begin
            slave_addr_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== design/mrtu_out_reg.sv =====
// Result register: holds one result transaction until taken downstream.
// Uses mrtu_pkg::result_t.
module mrtu_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mrtu_pkg::result_t res_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output mrtu_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    mrtu_pkg::result_t res_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule
